// File: design/dtai_pkg.sv
// ----------------------------------------------------------------------------
// dtai_pkg
// Types, constants and helpers for the date-time interval adder.
// ----------------------------------------------------------------------------
package dtai_pkg;

  localparam int unsigned YearW = 14;
  localparam int unsigned MonW  = 4;
  localparam int unsigned DayW  = 5;
  localparam int unsigned HourW = 5;
  localparam int unsigned MinW  = 6;
  localparam int unsigned SecW  = 6;
  localparam int unsigned IvW   = 17;

  localparam logic [IvW-1:0] IvMax   = 17'd86399;
  localparam logic [IvW-1:0] IvReset = 17'd1;

  // floor(x / 3600) = (x * IvRecip) >> IvShift for x <= 86399
  localparam logic [16:0] IvRecip  = 17'd74566;
  localparam int unsigned IvShift  = 28;
  // floor(x / 60) = (x * MinRecip) >> MinShift for x < 4096
  localparam logic [12:0] MinRecip = 13'd4370;
  localparam int unsigned MinShift = 18;
  // floor(y / 25) = (y * Y25Recip) >> Y25Shift for y < 16384
  localparam logic [12:0] Y25Recip = 13'd5243;
  localparam int unsigned Y25Shift = 17;

  localparam logic [11:0] SecPerHour = 12'd3600;
  localparam logic [6:0]  SecPerMin  = 7'd60;
  localparam logic [6:0]  MaxSec     = 7'd59;
  localparam logic [6:0]  MaxMin     = 7'd59;
  localparam logic [5:0]  MaxHour    = 6'd23;
  localparam logic [5:0]  HourPerDay = 6'd24;
  localparam logic [4:0]  Div25      = 5'd25;

  localparam logic [MonW-1:0] MonJan = 4'd1;
  localparam logic [MonW-1:0] MonFeb = 4'd2;
  localparam logic [MonW-1:0] MonApr = 4'd4;
  localparam logic [MonW-1:0] MonJun = 4'd6;
  localparam logic [MonW-1:0] MonSep = 4'd9;
  localparam logic [MonW-1:0] MonNov = 4'd11;
  localparam logic [MonW-1:0] MonDec = 4'd12;

  localparam logic [DayW-1:0] DayFirst = 5'd1;
  localparam logic [DayW-1:0] Len28    = 5'd28;
  localparam logic [DayW-1:0] Len29    = 5'd29;
  localparam logic [DayW-1:0] Len30    = 5'd30;
  localparam logic [DayW-1:0] Len31    = 5'd31;

  typedef struct packed {
    logic [YearW-1:0] in_year;
    logic [MonW-1:0]  in_month;
    logic [DayW-1:0]  in_day;
    logic [HourW-1:0] in_hour;
    logic [MinW-1:0]  in_minute;
    logic [SecW-1:0]  in_second;
  } in_item_t;

  typedef struct packed {
    logic [YearW-1:0] out_year;
    logic [MonW-1:0]  out_month;
    logic [DayW-1:0]  out_day;
    logic [HourW-1:0] out_hour;
    logic [MinW-1:0]  out_minute;
    logic [SecW-1:0]  out_second;
  } out_item_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] month,
                                                input logic leap);
    logic [DayW-1:0] len;
    case (month) inside
      MonApr, MonJun, MonSep, MonNov: len = Len30;
      MonFeb:                         len = leap ? Len29 : Len28;
      default:                        len = Len31;
    endcase
    return len;
  endfunction

endpackage

// File: design/date_time_add_interval_unit.sv
// ----------------------------------------------------------------------------
// date_time_add_interval_unit
// Adds the configured interval (under one day) to a Gregorian date-time.
// ----------------------------------------------------------------------------
// Five-stage pipeline: a new date-time may be started every cycle and its
// result appears on out_data with out_valid once it has left stage five. The
// receiver cannot stall, so busy stays low. The depth is set by the
// reciprocal multiplies that split the interval into h/m/s and test the
// year for divisibility by 25. Interval writes take effect at once and are
// saturated to 86399 s; write only while no transfer is in flight.
module date_time_add_interval_unit
  import dtai_pkg::*;
(
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  in_item_t       in_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [IvW-1:0] cfg_data,
  output logic           out_valid,
  output out_item_t      out_data
);

  logic [IvW-1:0] interval_r, interval_nxt;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  in_item_t   d1_r, d2_r, d3_r, d4_r;
  logic [4:0] ih1_r, ih2_r, ih3_r, ih4_r;
  logic [9:0] yq1_r;
  logic       leap2_r;
  logic [11:0] rem2_r, rem3_r;
  logic [5:0] im3_r, im4_r;
  logic [DayW-1:0] dmax3_r;
  logic [SecW-1:0] sec4_r;
  logic            cs4_r;
  logic [YearW-1:0] ny4_r;
  logic [MonW-1:0]  nm4_r;
  logic [DayW-1:0]  nd4_r;
  out_item_t        out_r;

  // stage 1
  logic [33:0] ih_prod;
  logic [26:0] yq_prod;
  // stage 2
  logic [IvW-1:0]   rem_full;
  logic [YearW-1:0] y25_rem;
  logic             leap;
  // stage 3
  logic [24:0] im_prod;
  // stage 4
  logic [11:0] is_full;
  logic [6:0]  s_sum;
  logic [6:0]  s_adj;
  logic        s_carry;
  logic [YearW-1:0] ny;
  logic [MonW-1:0]  nm;
  logic [DayW-1:0]  nd;
  // stage 5
  logic [6:0]  m_sum;
  logic [6:0]  m_adj;
  logic        m_carry;
  logic [5:0]  h_sum;
  logic [5:0]  h_adj;
  out_item_t   out_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign out_valid = v5_r;
  assign out_data  = out_r;

  assign interval_nxt = (cfg_data > IvMax) ? IvMax : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= IvReset;
    end else if (cfg_valid && cfg_ready) begin
      interval_r <= interval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stage 1: hours of interval, year / 25
  always_comb begin
    ih_prod = 34'(interval_r) * 34'(IvRecip);
    yq_prod = 27'(in_data.in_year) * 27'(Y25Recip);
  end

  always_ff @(posedge clk) begin
    d1_r  <= in_data;
    ih1_r <= ih_prod[IvShift+4:IvShift];
    yq1_r <= yq_prod[Y25Shift+9:Y25Shift];
  end

  // stage 2: interval remainder, leap year
  always_comb begin
    rem_full = interval_r - 17'(ih1_r) * 17'(SecPerHour);
    y25_rem  = d1_r.in_year - 14'(yq1_r) * 14'(Div25);
    leap     = (d1_r.in_year[1:0] == 2'd0) &&
               ((y25_rem != '0) || (d1_r.in_year[3:0] == 4'd0));
  end

  always_ff @(posedge clk) begin
    d2_r    <= d1_r;
    ih2_r   <= ih1_r;
    rem2_r  <= rem_full[11:0];
    leap2_r <= leap;
  end

  // stage 3: minutes of interval, month length
  assign im_prod = 25'(rem2_r) * 25'(MinRecip);

  always_ff @(posedge clk) begin
    d3_r    <= d2_r;
    ih3_r   <= ih2_r;
    rem3_r  <= rem2_r;
    im3_r   <= im_prod[MinShift+5:MinShift];
    dmax3_r <= month_len(d2_r.in_month, leap2_r);
  end

  // stage 4: seconds add, next-day candidate
  always_comb begin
    is_full = rem3_r - 12'(im3_r) * 12'(SecPerMin);
    s_sum   = 7'(d3_r.in_second) + 7'(is_full[5:0]);
    s_carry = (s_sum > MaxSec);
    s_adj   = s_carry ? (s_sum - SecPerMin) : s_sum;

    ny = d3_r.in_year;
    nm = d3_r.in_month;
    nd = DayFirst;
    if (d3_r.in_day < dmax3_r) begin
      nd = d3_r.in_day + DayFirst;
    end else if ((d3_r.in_day == dmax3_r) && (d3_r.in_month != MonDec)) begin
      nm = d3_r.in_month + 4'd1;
    end else begin
      nm = MonJan;
      ny = d3_r.in_year + 14'd1;
    end
  end

  always_ff @(posedge clk) begin
    d4_r   <= d3_r;
    ih4_r  <= ih3_r;
    im4_r  <= im3_r;
    sec4_r <= s_adj[5:0];
    cs4_r  <= s_carry;
    ny4_r  <= ny;
    nm4_r  <= nm;
    nd4_r  <= nd;
  end

  // stage 5: minutes, hours, day carry
  always_comb begin
    m_sum   = 7'(d4_r.in_minute) + 7'(im4_r) + 7'(cs4_r);
    m_carry = (m_sum > MaxMin);
    m_adj   = m_carry ? (m_sum - SecPerMin) : m_sum;
    h_sum   = 6'(d4_r.in_hour) + 6'(ih4_r) + 6'(m_carry);

    out_nxt.out_second = sec4_r;
    out_nxt.out_minute = m_adj[5:0];
    if (h_sum > MaxHour) begin
      h_adj             = h_sum - HourPerDay;
      out_nxt.out_year  = ny4_r;
      out_nxt.out_month = nm4_r;
      out_nxt.out_day   = nd4_r;
    end else begin
      h_adj             = h_sum;
      out_nxt.out_year  = d4_r.in_year;
      out_nxt.out_month = d4_r.in_month;
      out_nxt.out_day   = d4_r.in_day;
    end
    out_nxt.out_hour = h_adj[4:0];
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule
